### design/nta_pkg.sv
// Shared types, constants and helpers for the number-to-ASCII formatter.
`timescale 1ns / 1ps

package nta_pkg;

   localparam int VALUE_W        = 16;
   localparam int CHAR_W         = 7;
   localparam int IPART_W        = 3;
   localparam int FRAC_WIDTH_DEF = 13;
   localparam int SCALE          = 10000;
   localparam int SCALE_W        = 14;
   localparam int FRAC_MAX       = 9999;
   localparam int DEC_DIGITS     = 5;
   localparam int HEX_DIGITS     = 4;
   localparam int TEXT_LEN       = 6;
   localparam int LEN_W          = 3;
   localparam int QUEUE_DEPTH    = 2;

   // x / 10 == (x * 52429) >> 19 for every 16-bit x
   localparam int DIV10_MUL   = 52429;
   localparam int DIV10_SHIFT = 19;
   localparam int PROD_W      = 32;

   localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CH_A     = 7'h41;
   localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;

   typedef enum logic [1:0] {
      CMD_DEC  = 2'd0,
      CMD_HEX  = 2'd1,
      CMD_FIX  = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   // One classified word travelling from the front to the back.
   typedef struct packed {
      cmd_type              mode;
      logic [VALUE_W-1:0]   number;
      logic [IPART_W-1:0]   ipart;
   } item_type;

   typedef struct packed {
      logic             cv_busy;
      logic             cv_done;
      logic [LEN_W-1:0] em_left;
   } back_status_type;

   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d);
      logic [CHAR_W-1:0] c;
      if (d < 4'd10) begin
         c = CH_ZERO + CHAR_W'(d);
      end else begin
         c = CH_A + CHAR_W'(d - 4'd10);
      end
      return c;
   endfunction

endpackage

### design/nta_front.sv
// Front end: accepts words, drops unused commands, scales and rounds the fraction.
`timescale 1ns / 1ps

module nta_front
   import nta_pkg::*;
#(
   parameter int FRAC_WIDTH = FRAC_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic [VALUE_W-1:0] req_value,
   output logic               out_valid,
   input  logic               out_ready,
   output item_type           out_item
);

   localparam int ACC_W = FRAC_WIDTH + SCALE_W;
   localparam int INT_W = VALUE_W - FRAC_WIDTH;
   localparam logic [SCALE_W:0]   RND_MAX = (SCALE_W + 1)'(FRAC_MAX);
   localparam logic [ACC_W-1:0]   SCALE_K = ACC_W'(SCALE);

   logic               a_valid_ff, a_valid_in;
   cmd_type            a_cmd_ff, a_cmd_in;
   logic [VALUE_W-1:0] a_value_ff, a_value_in;

   logic               b_valid_ff, b_valid_in;
   cmd_type            b_mode_ff, b_mode_in;
   logic [VALUE_W-1:0] b_value_ff, b_value_in;
   logic [IPART_W-1:0] b_ipart_ff, b_ipart_in;
   logic [ACC_W-1:0]   b_acc_ff, b_acc_in;

   logic               a_ready, b_ready;
   logic [ACC_W-1:0]   a_prod;
   logic [SCALE_W:0]   b_round;
   logic [SCALE_W-1:0] b_frac;

   assign b_ready   = !b_valid_ff || out_ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign req_ready = a_ready;

   assign a_prod = ACC_W'(a_value_ff[FRAC_WIDTH-1:0]) * SCALE_K;

   // round half up, then clamp a carry into the integer digit back to 9999
   assign b_round = {1'b0, b_acc_ff[ACC_W-1:FRAC_WIDTH]}
                    + (SCALE_W + 1)'(b_acc_ff[FRAC_WIDTH-1]);
   assign b_frac  = (b_round > RND_MAX) ? SCALE_W'(FRAC_MAX) : b_round[SCALE_W-1:0];

   always_comb begin
      a_valid_in = a_valid_ff;
      a_cmd_in   = a_cmd_ff;
      a_value_in = a_value_ff;
      if (a_ready) begin
         a_valid_in = req_valid && (cmd_type'(req_command) != CMD_NONE);
         a_cmd_in   = cmd_type'(req_command);
         a_value_in = req_value;
      end

      b_valid_in = b_valid_ff;
      b_mode_in  = b_mode_ff;
      b_value_in = b_value_ff;
      b_ipart_in = b_ipart_ff;
      b_acc_in   = b_acc_ff;
      if (b_ready) begin
         b_valid_in = a_valid_ff;
         b_mode_in  = a_cmd_ff;
         b_value_in = a_value_ff;
         b_ipart_in = IPART_W'(a_value_ff[VALUE_W-1:VALUE_W-INT_W]);
         b_acc_in   = a_prod;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
      a_cmd_ff   <= a_cmd_in;
      a_value_ff <= a_value_in;
      b_mode_ff  <= b_mode_in;
      b_value_ff <= b_value_in;
      b_ipart_ff <= b_ipart_in;
      b_acc_ff   <= b_acc_in;
   end

   assign out_valid       = b_valid_ff;
   assign out_item.mode   = b_mode_ff;
   assign out_item.number = (b_mode_ff == CMD_FIX) ? VALUE_W'(b_frac) : b_value_ff;
   assign out_item.ipart  = b_ipart_ff;

endmodule

### design/nta_fifo.sv
// Small register queue between the front and the back.
`timescale 1ns / 1ps

module nta_fifo
   import nta_pkg::*;
#(
   parameter int WIDTH = $bits(item_type),
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### design/nta_back.sv
// Back end: digit converter (one digit a cycle) feeding a character shift-out stage.
`timescale 1ns / 1ps

module nta_back
   import nta_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  item_type          in_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CHAR_W-1:0] rsp_character,
   output logic              rsp_last,
   output back_status_type   status
);

   localparam logic [LEN_W-1:0] LEN_HEX = LEN_W'(HEX_DIGITS);
   localparam logic [LEN_W-1:0] LEN_FIX = LEN_W'(TEXT_LEN);
   localparam logic [LEN_W-1:0] STEP_LAST = LEN_W'(HEX_DIGITS - 1);

   logic               cv_busy_ff, cv_busy_in;
   logic               cv_done_ff, cv_done_in;
   cmd_type            cv_mode_ff, cv_mode_in;
   logic [VALUE_W-1:0] cv_num_ff, cv_num_in;
   logic [IPART_W-1:0] cv_ipart_ff, cv_ipart_in;
   logic [LEN_W-1:0]   cv_cnt_ff, cv_cnt_in;
   logic [CHAR_W-1:0]  cv_chars_ff [DEC_DIGITS];
   logic [CHAR_W-1:0]  cv_chars_in [DEC_DIGITS];

   logic [LEN_W-1:0]   em_left_ff, em_left_in;
   logic [CHAR_W-1:0]  em_chars_ff [TEXT_LEN];
   logic [CHAR_W-1:0]  em_chars_in [TEXT_LEN];

   logic               em_free, handoff, load, last_step;
   logic [PROD_W-1:0]  div_prod;
   logic [VALUE_W-1:0] quot, rem;
   logic [3:0]         digit;
   logic [VALUE_W-1:0] num_next;

   assign em_free  = (em_left_ff == '0) || ((em_left_ff == LEN_W'(1)) && rsp_ready);
   assign handoff  = cv_done_ff && em_free;
   assign in_ready = !cv_busy_ff && (!cv_done_ff || handoff);
   assign load     = in_valid && in_ready;

   // divide by ten through the reciprocal, remainder by shift and subtract
   assign div_prod = PROD_W'(cv_num_ff) * PROD_W'(DIV10_MUL);
   assign quot     = VALUE_W'(div_prod[PROD_W-1:DIV10_SHIFT]);
   assign rem      = cv_num_ff - (quot << 3) - (quot << 1);

   always_comb begin
      if (cv_mode_ff == CMD_HEX) begin
         digit    = cv_num_ff[3:0];
         num_next = cv_num_ff >> 4;
      end else begin
         digit    = rem[3:0];
         num_next = quot;
      end
      if (cv_mode_ff == CMD_DEC) begin
         last_step = (quot == '0);
      end else begin
         last_step = (cv_cnt_ff == STEP_LAST);
      end
   end

   always_comb begin
      cv_busy_in  = cv_busy_ff;
      cv_done_in  = cv_done_ff;
      cv_mode_in  = cv_mode_ff;
      cv_num_in   = cv_num_ff;
      cv_ipart_in = cv_ipart_ff;
      cv_cnt_in   = cv_cnt_ff;
      cv_chars_in = cv_chars_ff;

      if (handoff) begin
         cv_done_in = 1'b0;
      end
      if (load) begin
         cv_busy_in  = 1'b1;
         cv_mode_in  = in_item.mode;
         cv_num_in   = in_item.number;
         cv_ipart_in = in_item.ipart;
         cv_cnt_in   = '0;
      end else if (cv_busy_ff) begin
         // digits come out least significant first: push at the head
         cv_chars_in[0] = hex_char(digit);
         for (int i = 1; i < DEC_DIGITS; i++) begin
            cv_chars_in[i] = cv_chars_ff[i-1];
         end
         cv_num_in = num_next;
         cv_cnt_in = cv_cnt_ff + LEN_W'(1);
         if (last_step) begin
            cv_busy_in = 1'b0;
            cv_done_in = 1'b1;
         end
      end
   end

   always_comb begin
      em_left_in  = em_left_ff;
      em_chars_in = em_chars_ff;
      if (handoff) begin
         priority case (cv_mode_ff)
            CMD_FIX: begin
               em_chars_in[0] = CH_ZERO + CHAR_W'(cv_ipart_ff);
               em_chars_in[1] = CH_POINT;
               for (int i = 0; i < HEX_DIGITS; i++) begin
                  em_chars_in[i+2] = cv_chars_ff[i];
               end
               em_left_in = LEN_FIX;
            end
            CMD_HEX: begin
               for (int i = 0; i < DEC_DIGITS; i++) begin
                  em_chars_in[i] = cv_chars_ff[i];
               end
               em_left_in = LEN_HEX;
            end
            default: begin
               for (int i = 0; i < DEC_DIGITS; i++) begin
                  em_chars_in[i] = cv_chars_ff[i];
               end
               em_left_in = cv_cnt_ff;
            end
         endcase
      end else if (rsp_valid && rsp_ready) begin
         // advance: drop the character just taken
         for (int i = 0; i < TEXT_LEN - 1; i++) begin
            em_chars_in[i] = em_chars_ff[i+1];
         end
         em_left_in = em_left_ff - LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_busy_ff <= 1'b0;
         cv_done_ff <= 1'b0;
         em_left_ff <= '0;
      end else begin
         cv_busy_ff <= cv_busy_in;
         cv_done_ff <= cv_done_in;
         em_left_ff <= em_left_in;
      end
      cv_mode_ff  <= cv_mode_in;
      cv_num_ff   <= cv_num_in;
      cv_ipart_ff <= cv_ipart_in;
      cv_cnt_ff   <= cv_cnt_in;
      cv_chars_ff <= cv_chars_in;
      em_chars_ff <= em_chars_in;
   end

   assign rsp_valid      = (em_left_ff != '0);
   assign rsp_character  = em_chars_ff[0];
   assign rsp_last       = (em_left_ff == LEN_W'(1));
   assign status.cv_busy = cv_busy_ff;
   assign status.cv_done = cv_done_ff;
   assign status.em_left = em_left_ff;

endmodule

### design/number_to_ascii_formatter.sv
// Top level of the number-to-ASCII formatter: front end, queue and back end.
// Path: a word passes front-end stages a and b, the queue, the digit converter (one step
//   per decimal digit, or 4 for hex and fixed point) and the character shift-out stage.
// Overlap: the one-digit-a-cycle converter works on the next word while the output
//   shifts out the previous one, one character a cycle while rsp_ready is high.
// Reset: synchronous, active high; clears all flags, the queue and the em_left count.
`timescale 1ns / 1ps

module number_to_ascii_formatter
   import nta_pkg::*;
#(
   parameter int FRAC_WIDTH = FRAC_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic [VALUE_W-1:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [CHAR_W-1:0]  rsp_character,
   output logic               rsp_last
);

   localparam int ITEM_W = $bits(item_type);

   logic            fr_valid, fr_ready;
   item_type        fr_item;
   logic            q_valid, q_ready;
   logic [ITEM_W-1:0] q_data;
   back_status_type bk_st;

   nta_front #(
      .FRAC_WIDTH (FRAC_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .req_value   (req_value),
      .out_valid   (fr_valid),
      .out_ready   (fr_ready),
      .out_item    (fr_item)
   );

   nta_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .push_data  (fr_item),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   nta_back u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (q_valid),
      .in_ready      (q_ready),
      .in_item       (item_type'(q_data)),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last),
      .status        (bk_st)
   );

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !bk_st.cv_busy && !bk_st.cv_done)
      else $error("back end not idle after reset");

   a_conv_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(bk_st.cv_busy && bk_st.cv_done))
      else $error("converter busy and done at once");

   a_word_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("text broken off before its last character");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      bk_st.em_left <= LEN_W'(TEXT_LEN))
      else $error("output length out of range");

endmodule

### verif/tb_number_to_ascii_formatter.sv
// Testbench for the number-to-ASCII formatter: queued words in, predicted text checked out.
`timescale 1ns / 1ps

module tb_number_to_ascii_formatter;
   import nta_pkg::*;

   localparam int FRACTION_W   = FRAC_WIDTH_DEF;
   localparam int RANDOM_WORDS = 290;
   localparam int CALM_WORDS   = 40;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      cmd_type            cmd;
      logic [VALUE_W-1:0] value;
   } word_type;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last;
   } char_type;

   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               req_valid     = 1'b0;
   logic               req_ready;
   logic [1:0]         req_command   = CMD_NONE;
   logic [VALUE_W-1:0] req_value     = '0;
   logic               rsp_valid;
   logic               rsp_ready     = 1'b0;
   logic [CHAR_W-1:0]  rsp_character;
   logic               rsp_last;

   word_type pending_words[$];
   char_type expected_chars[$];
   word_type next_word;
   char_type want;

   int  words_total = 0;
   int  words_sent  = 0;
   int  calm_from   = 1 << 30;
   int  send_gap    = 0;
   int  stall_left  = 0;
   int  failures    = 0;
   int  cycles      = 0;
   logic calm;

   assign calm = (words_sent >= calm_from);

   number_to_ascii_formatter #(
      .FRAC_WIDTH(FRACTION_W)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_character(rsp_character),
      .rsp_last     (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void note_failure(string msg);
      failures++;
      if (failures <= REPORT_MAX) begin
         $display("MISMATCH: %s", msg);
      end
   endfunction

   // Work out the characters one word produces and append them to the expected text.
   function automatic void format_text(cmd_type cmd, logic [VALUE_W-1:0] val);
      logic [CHAR_W-1:0] txt[TEXT_LEN];
      int n;
      int i;
      int x;
      int acc;
      int frac;
      logic [3:0] nib;
      char_type c;
      n = 0;
      case (cmd)
         CMD_DEC: begin
            x = int'(val);
            n = (val < 10) ? 1 : (val < 100) ? 2 : (val < 1000) ? 3 : (val < 10000) ? 4 : 5;
            for (i = n - 1; i >= 0; i--) begin
               txt[i] = CH_ZERO + CHAR_W'(x % 10);
               x = x / 10;
            end
         end
         CMD_HEX: begin
            n = HEX_DIGITS;
            for (i = 0; i < HEX_DIGITS; i++) begin
               nib = val[4*(HEX_DIGITS-1-i) +: 4];
               txt[i] = (nib < 10) ? CH_ZERO + CHAR_W'(nib) : CH_A + CHAR_W'(nib - 10);
            end
         end
         CMD_FIX: begin
            n = TEXT_LEN;
            acc = int'(val & ((1 << FRACTION_W) - 1)) * SCALE;
            frac = acc >> FRACTION_W;
            // round half up, then clamp so a carry never reaches the integer digit
            if (((acc >> (FRACTION_W - 1)) & 1) != 0) frac++;
            if (frac > FRAC_MAX) frac = FRAC_MAX;
            txt[0] = CH_ZERO + CHAR_W'(val >> FRACTION_W);
            txt[1] = CH_POINT;
            for (i = TEXT_LEN - 1; i > 1; i--) begin
               txt[i] = CH_ZERO + CHAR_W'(frac % 10);
               frac = frac / 10;
            end
         end
         default: n = 0;
      endcase
      for (i = 0; i < n; i++) begin
         c.character = txt[i];
         c.last      = (i == n - 1);
         expected_chars.push_back(c);
      end
   endfunction

   function automatic void queue_word(cmd_type cmd, logic [VALUE_W-1:0] val);
      word_type w;
      w.cmd   = cmd;
      w.value = val;
      pending_words.push_back(w);
      words_total++;
   endfunction

   // Driver: present queued words, with random gaps between them.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready) begin
            format_text(cmd_type'(req_command), req_value);
            words_sent <= words_sent + 1;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               req_valid <= 1'b0;
               send_gap  <= send_gap - 1;
            end else if (pending_words.size() != 0) begin
               next_word = pending_words.pop_front();
               req_valid   <= 1'b1;
               req_command <= next_word.cmd;
               req_value   <= next_word.value;
               if (!calm && $urandom_range(0, 3) == 0) begin
                  send_gap <= $urandom_range(1, 16);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each character against the oldest expected one, stall in bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               note_failure($sformatf("unexpected character %h last %b",
                                      rsp_character, rsp_last));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_character !== want.character || rsp_last !== want.last) begin
                  note_failure($sformatf("character %h last %b, expected %h last %b",
                                         rsp_character, rsp_last,
                                         want.character, want.last));
               end
            end
         end
         if (stall_left > 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 15);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      cmd_type            cmd;
      logic [VALUE_W-1:0] val;
      int                 real_words;
      real_words = 0;

      // decimal digit-count boundaries
      queue_word(CMD_DEC, 16'd0);
      queue_word(CMD_DEC, 16'd9);
      queue_word(CMD_DEC, 16'd10);
      queue_word(CMD_DEC, 16'd99);
      queue_word(CMD_DEC, 16'd100);
      queue_word(CMD_DEC, 16'd999);
      queue_word(CMD_DEC, 16'd1000);
      queue_word(CMD_DEC, 16'd9999);
      queue_word(CMD_DEC, 16'd10000);
      queue_word(CMD_DEC, 16'hFFFF);
      queue_word(CMD_HEX, 16'h0000);
      queue_word(CMD_HEX, 16'hFFFF);
      queue_word(CMD_HEX, 16'h09AF);
      // fixed point: zero, all ones, fraction near one, exact half, whole number, smallest fraction
      queue_word(CMD_FIX, 16'h0000);
      queue_word(CMD_FIX, 16'hFFFF);
      queue_word(CMD_FIX, 16'h1FFF);
      queue_word(CMD_FIX, 16'h0100);
      queue_word(CMD_FIX, 16'h2000);
      queue_word(CMD_FIX, 16'hE001);
      // unused command: dropped by the block
      queue_word(CMD_NONE, 16'h1234);
      queue_word(CMD_NONE, 16'hFFFF);

      while (real_words < RANDOM_WORDS) begin
         if ($urandom_range(0, 19) == 0) begin
            cmd = CMD_NONE;
         end else begin
            cmd = cmd_type'($urandom_range(0, 2));
         end
         case ($urandom_range(0, 9))
            0: val = VALUE_W'($urandom_range(0, 9));
            1: val = VALUE_W'($urandom_range(10, 99));
            2: val = VALUE_W'($urandom_range(100, 999));
            3: val = VALUE_W'($urandom_range(1000, 9999));
            4: val = $urandom_range(0, 1) ? VALUE_W'(16'hFFFF - $urandom_range(0, 3))
                                          : VALUE_W'($urandom_range(9995, 10005));
            default: val = VALUE_W'($urandom_range(0, 65535));
         endcase
         queue_word(cmd, val);
         if (cmd != CMD_NONE) real_words++;
      end
      calm_from = words_total - CALM_WORDS;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (words_sent < words_total) @(negedge clock);
      while (expected_chars.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (expected_chars.size() != 0) begin
         note_failure($sformatf("%0d characters never arrived", expected_chars.size()));
      end
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
